[src/mbe_pkg.sv]
// shared types and constants of the mandelbrot escape-time unit
`default_nettype none

package mbe_pkg;

  // fixed field widths
  localparam int COORD_W = 32;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int COUNT_W = 10;

  // configuration port
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam int REG_IDX_W = 1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = 1'b0;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 10'd511;

  // controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic stop;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[src/mbe_ctrl.sv]
// controller state machine for the escape-time iteration
`default_nettype none

module mbe_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire mbe_pkg::sts_t sts,
  output mbe_pkg::cmd_t     cmd
);

  mbe_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      mbe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mbe_pkg::ST_MUL;
        end
      end
      mbe_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = mbe_pkg::ST_UPD;
      end
      mbe_pkg::ST_UPD: begin
        if (!sts.stop) begin
          cmd.step  = 1'b1;
          state_nxt = mbe_pkg::ST_MUL;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = mbe_pkg::ST_IDLE;
        end else begin
          state_nxt = mbe_pkg::ST_HOLD;
        end
      end
      mbe_pkg::ST_HOLD: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = mbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mbe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/mbe_dpath.sv]
// datapath: z registers, squarers, escape test, counter and output word
`default_nettype none

module mbe_dpath #(
  parameter int FRAC_BITS = 28
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mbe_pkg::cmd_t                 cmd,
  output mbe_pkg::sts_t                      sts,
  input  wire logic [mbe_pkg::COUNT_W-1:0]   iteration_limit,
  input  wire logic signed [mbe_pkg::COORD_W-1:0] in_point_real,
  input  wire logic signed [mbe_pkg::COORD_W-1:0] in_point_imag,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mbe_pkg::COUNT_W-1:0]        out_iteration_count
);

  localparam int ESC_SH = 2 * FRAC_BITS + 2;

  logic signed [mbe_pkg::COORD_W-1:0] cr_r, ci_r, zr_r, zi_r;
  logic signed [mbe_pkg::PROD_W-1:0]  rr_r, ii_r, ri_r;
  logic [mbe_pkg::COUNT_W-1:0]        count_r;
  logic                               out_valid_r;
  logic [mbe_pkg::COUNT_W-1:0]        out_count_r;

  logic [mbe_pkg::PROD_W-1:0]         mag_sum;
  logic signed [mbe_pkg::PROD_W-1:0]  re_diff, re_shift, im_shift;
  logic signed [mbe_pkg::COORD_W-1:0] zr_nxt, zi_nxt;
  logic                               escaped;

  // squared magnitude, exact at double width
  assign mag_sum = $unsigned(rr_r) + $unsigned(ii_r);

  // threshold 4 lies beyond 64 bits for very wide fractions
  generate
    if (ESC_SH >= mbe_pkg::PROD_W) begin : g_no_esc
      assign escaped = 1'b0;
    end else begin : g_esc
      assign escaped = |mag_sum[mbe_pkg::PROD_W-1:ESC_SH];
    end
  endgenerate

  // next z, floor scaling by arithmetic shift, wrapped to 32 bits
  assign re_diff  = rr_r - ii_r;
  assign re_shift = re_diff >>> FRAC_BITS;
  assign im_shift = ri_r >>> (FRAC_BITS - 1);
  assign zr_nxt   = re_shift[mbe_pkg::COORD_W-1:0] + cr_r;
  assign zi_nxt   = im_shift[mbe_pkg::COORD_W-1:0] + ci_r;

  // status to controller
  assign sts.stop     = (count_r >= iteration_limit) || escaped;
  assign sts.out_free = !out_valid_r || out_ready;

  // point and z registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r <= in_point_real;
      ci_r <= in_point_imag;
      zr_r <= in_point_real;
      zi_r <= in_point_imag;
    end else if (cmd.step) begin
      zr_r <= zr_nxt;
      zi_r <= zi_nxt;
    end
  end

  // product registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rr_r <= zr_r * zr_r;
      ii_r <= zi_r * zi_r;
      ri_r <= zr_r * zi_r;
    end
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load) begin
      count_r <= '0;
    end else if (cmd.step) begin
      count_r <= count_r + mbe_pkg::COUNT_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count_r <= count_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;

  // a step is only taken below the limit
  a_step_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (count_r < iteration_limit))
    else $error("iteration step taken at or beyond the limit");

  // a result never overwrites a word still waiting
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result emitted into an occupied output slot");

  // a new point starts from a cleared count
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (count_r == '0))
    else $error("count not cleared on new point");

endmodule

`default_nettype wire

[src/mandelbrot_escape_time.sv]
// top level of the mandelbrot escape-time unit with its register port
//
// channel   direction  handshake             contents
// in_       input      in_valid / in_ready   point_real, point_imag (Q4.28)
// out_      output     out_valid / out_ready iteration_count
// apb       input      psel/penable/pwrite   iteration_limit at address 0
//
// one point is worked on at a time; each iteration runs the squarers in
// ST_MUL, then the escape test and z update in ST_UPD, and a point holds the
// unit until its count is emitted
// the output register lets a new point start while a count waits to be taken
// a finished count stalls the unit only while the output word is still held
// synchronous active-low reset; iteration_limit resets to 511
`default_nettype none

module mandelbrot_escape_time #(
  parameter int FRAC_BITS = 28
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [mbe_pkg::COORD_W-1:0] in_point_real,
  input  wire logic signed [mbe_pkg::COORD_W-1:0] in_point_imag,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [mbe_pkg::COUNT_W-1:0]             out_iteration_count,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mbe_pkg::APB_AW-1:0]         paddr,
  input  wire logic [mbe_pkg::APB_DW-1:0]         pwdata,
  output logic [mbe_pkg::APB_DW-1:0]              prdata,
  output logic                                    pready
);

  logic [mbe_pkg::COUNT_W-1:0]   limit_r;
  logic [mbe_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;
  mbe_pkg::cmd_t                 cmd;
  mbe_pkg::sts_t                 sts;

  // register decode
  assign reg_idx = paddr[mbe_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mbe_pkg::LIMIT_RESET;
    end else if (cfg_wr && (reg_idx == mbe_pkg::REG_ITER_LIMIT)) begin
      limit_r <= pwdata[mbe_pkg::COUNT_W-1:0];
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    if (reg_idx == mbe_pkg::REG_ITER_LIMIT) begin
      prdata = mbe_pkg::APB_DW'(limit_r);
    end
  end

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbe_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .iteration_limit     (limit_r),
    .in_point_real       (in_point_real),
    .in_point_imag       (in_point_imag),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_iteration_count (out_iteration_count)
  );

endmodule

`default_nettype wire
